>>> rtl/core/assert_macros.svh
// Assertion helpers; bodies vanish for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on clk, off while rst_n is low.
`define MBSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked on clk, off while rst_n is low.
`define MBSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MBSA_ASSERT_IMP(lbl, ante, cons, msg)
`define MBSA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/core/mbsa_pkg.sv
`default_nettype none
package mbsa_pkg;

  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] SYSEX_END   = 8'hF7;

  // Command handed from the front to the back.
  typedef struct packed {
    logic        drain;   // 1: emit the buffered sysex run
    logic [23:0] word;
    logic [1:0]  len;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_push_t;

  // Message length from status bits 6:4; every Fx byte is one byte long.
  function automatic logic [1:0] status_length(input logic [2:0] hi);
    logic [1:0] len;
    case (hi)
      3'd4, 3'd5: len = 2'd2;
      3'd7:       len = 2'd1;
      default:    len = 2'd3;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/mbsa_ram.sv
`default_nettype none
module mbsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

>>> rtl/core/mbsa_front.sv
`default_nettype none
module mbsa_front import mbsa_pkg::*; #(
  parameter int SYSEX_CAPACITY = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire logic [7:0]                          in_byte,
  output      logic                                wr_en,
  output      logic [$clog2(SYSEX_CAPACITY)-1:0]   wr_addr,
  output      logic [7:0]                          wr_data,
  output      cmd_push_t                           push,
  input  wire logic                                q_full,
  output      logic [$clog2(SYSEX_CAPACITY+1)-1:0] run_len,
  input  wire logic                                drain_done
);

  localparam int CW = $clog2(SYSEX_CAPACITY + 1);
  localparam int AW = $clog2(SYSEX_CAPACITY);

  logic [CW-1:0] pos_r, pos_nxt, pos_a;
  logic [1:0]    exp_r, exp_nxt, exp_a;
  logic [23:0]   word_r, word_nxt, word_a, lane;
  logic          sysex_r, sysex_nxt, sysex_a;
  logic          done_r, done_nxt, done_a;
  logic          busy_r, busy_nxt;
  logic          restart, accept;

  // Hold input while the queue is full or a sysex run is still draining.
  assign in_stall = q_full || busy_r;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    restart = in_byte[7] && !(in_byte == SYSEX_END && sysex_r);
    pos_a   = restart ? '0 : pos_r;
    exp_a   = restart ? status_length(in_byte[6:4]) : exp_r;
    word_a  = restart ? '0 : word_r;
    done_a  = restart ? 1'b0 : done_r;
    sysex_a = sysex_r || (restart && in_byte == SYSEX_START);

    pos_nxt   = pos_r;
    exp_nxt   = exp_r;
    word_nxt  = word_r;
    done_nxt  = done_r;
    sysex_nxt = sysex_r;
    busy_nxt  = busy_r;
    wr_en     = 1'b0;
    push      = '0;
    lane      = '0;

    if (accept) begin
      pos_nxt   = pos_a;
      exp_nxt   = exp_a;
      word_nxt  = word_a;
      done_nxt  = done_a;
      sysex_nxt = sysex_a;
      if (sysex_a) begin
        if (pos_a < CW'(SYSEX_CAPACITY)) begin
          wr_en   = 1'b1;
          pos_nxt = pos_a + 1'b1;
        end
        // Drain on end of sysex or a full buffer.
        if (in_byte == SYSEX_END || pos_nxt >= CW'(SYSEX_CAPACITY)) begin
          sysex_nxt      = 1'b0;
          push.valid     = 1'b1;
          push.cmd.drain = 1'b1;
          busy_nxt       = 1'b1;
        end
      end else if (exp_a != 2'd0 && !done_a && pos_a < CW'(3)) begin
        case (pos_a[1:0])
          2'd0:    lane = {16'h0000, in_byte};
          2'd1:    lane = {8'h00, in_byte, 8'h00};
          default: lane = {in_byte, 16'h0000};
        endcase
        word_nxt = word_a | lane;
        pos_nxt  = pos_a + 1'b1;
        if (pos_nxt == CW'(exp_a)) begin
          done_nxt      = 1'b1;
          push.valid    = 1'b1;
          push.cmd.word = word_nxt;
          push.cmd.len  = exp_a;
        end
      end
    end

    if (drain_done) begin
      busy_nxt = 1'b0;
    end
  end

  assign wr_addr = pos_a[AW-1:0];
  assign wr_data = in_byte;
  // Position holds while the run drains, so it doubles as the run length.
  assign run_len = pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      exp_r   <= '0;
      word_r  <= '0;
      sysex_r <= 1'b0;
      done_r  <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      exp_r   <= exp_nxt;
      word_r  <= word_nxt;
      sysex_r <= sysex_nxt;
      done_r  <= done_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/mbsa_queue.sv
`default_nettype none
module mbsa_queue import mbsa_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cmd_push_t push,
  output      logic      full,
  input  wire logic      pop,
  output      logic      empty,
  output      cmd_t      head
);

  cmd_t       entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push.valid && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push.valid) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entry_r[wr_ptr_r] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push.valid) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/mbsa_back.sv
`default_nettype none
`include "assert_macros.svh"
module mbsa_back import mbsa_pkg::*; #(
  parameter int SYSEX_CAPACITY = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                q_empty,
  input  wire cmd_t                                q_head,
  output      logic                                q_pop,
  input  wire logic [$clog2(SYSEX_CAPACITY+1)-1:0] run_len,
  output      logic                                rd_en,
  output      logic [$clog2(SYSEX_CAPACITY)-1:0]   rd_addr,
  input  wire logic [7:0]                          rd_data,
  output      logic                                drain_done,
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      logic                                out_kind,
  output      logic [23:0]                         out_short_word,
  output      logic [1:0]                          out_short_length,
  output      logic [7:0]                          out_sysex_value,
  output      logic                                out_last_of_run
);

  localparam int CW = $clog2(SYSEX_CAPACITY + 1);
  localparam int AW = $clog2(SYSEX_CAPACITY);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt, idx_inc;
  logic          out_valid_r, out_valid_nxt;
  logic          out_kind_r, out_last_r;
  logic [23:0]   out_word_r;
  logic [1:0]    out_len_r;
  logic [7:0]    out_sx_r;
  logic          out_free, load_short, load_sysex, emit_last;

  assign out_free = !out_valid_r || !out_stall;
  assign idx_inc  = idx_r + 1'b1;
  assign emit_last = (idx_inc == run_len);
  assign rd_addr  = idx_r[AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    drain_done    = 1'b0;
    load_short    = 1'b0;
    load_sysex    = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          if (q_head.drain) begin
            idx_nxt   = '0;
            state_nxt = ST_READ;
          end else begin
            load_short    = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          load_sysex    = 1'b1;
          out_valid_nxt = 1'b1;
          if (emit_last) begin
            drain_done = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_short) begin
      out_kind_r <= 1'b0;
      out_word_r <= q_head.word;
      out_len_r  <= q_head.len;
      out_sx_r   <= '0;
      out_last_r <= 1'b1;
    end else if (load_sysex) begin
      out_kind_r <= 1'b1;
      out_word_r <= '0;
      out_len_r  <= '0;
      out_sx_r   <= rd_data;
      out_last_r <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_short_word   = out_word_r;
  assign out_short_length = out_len_r;
  assign out_sysex_value  = out_sx_r;
  assign out_last_of_run  = out_last_r;

  `MBSA_ASSERT_IMP(a_pop_nonempty, q_pop, !q_empty, "pop from empty command queue")
  `MBSA_ASSERT_IMP(a_short_whole, out_valid_r && !out_kind_r, out_last_r && out_len_r != 2'd0, "short word not marked as whole run")
  `MBSA_ASSERT_NXT(a_drain_end, drain_done, state_r == ST_IDLE && out_valid_r && out_kind_r && out_last_r, "run end not shown on output")

endmodule
`default_nettype wire

>>> rtl/core/midi_byte_stream_assembler_top.sv
`default_nettype none
// MIDI byte stream assembler. Each input word is one raw MIDI byte; a byte with
// bit 7 set is a status byte and restarts assembly. Short messages (length from
// status bits 6:4: 3,3,3,3,2,2,3,1, so every Fx byte stands alone) come out as
// one word with kind = 0, status in short_word[7:0] and data bytes above it,
// last_of_run = 1. Data bytes past the message length are dropped until the next
// status byte (no running status). F0 opens a sysex run: bytes go into an
// on-chip buffer of SYSEX_CAPACITY entries, and on F7 or a full buffer the whole
// run comes out one byte per word with kind = 1, last_of_run set on its final
// byte. A status byte other than F7 inside sysex restarts the buffer with that
// byte first. Rate: a short-message byte is taken every cycle while the
// two-entry command queue between the parsing front and the output back has
// room and no sysex run is draining. A sysex run is read back from the buffer's
// single registered read port a byte at a time, via a read state and then an
// emit state; input stalls from the cycle after the closing byte until the run's
// last byte is loaded into the output register. No clearing pass after reset.
module midi_byte_stream_assembler_top import mbsa_pkg::*; #(
  parameter int SYSEX_CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  in_byte,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        out_kind,
  output      logic [23:0] out_short_word,
  output      logic [1:0]  out_short_length,
  output      logic [7:0]  out_sysex_value,
  output      logic        out_last_of_run
);

  localparam int CW = $clog2(SYSEX_CAPACITY + 1);
  localparam int AW = $clog2(SYSEX_CAPACITY);

  // Buffer write side (front) and read side (back).
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  // Command queue between the two halves.
  cmd_push_t     push;
  cmd_t          q_head;
  logic          q_full, q_empty, q_pop;

  // Run length held by the front while the back drains the buffer.
  logic [CW-1:0] run_len;
  logic          drain_done;

  mbsa_front #(
    .SYSEX_CAPACITY(SYSEX_CAPACITY)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .push      (push),
    .q_full    (q_full),
    .run_len   (run_len),
    .drain_done(drain_done)
  );

  mbsa_ram #(
    .WIDTH(8),
    .DEPTH(SYSEX_CAPACITY)
  ) u_sysex_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  mbsa_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .full (q_full),
    .pop  (q_pop),
    .empty(q_empty),
    .head (q_head)
  );

  mbsa_back #(
    .SYSEX_CAPACITY(SYSEX_CAPACITY)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .run_len         (run_len),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .drain_done      (drain_done),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_short_word  (out_short_word),
    .out_short_length(out_short_length),
    .out_sysex_value (out_sysex_value),
    .out_last_of_run (out_last_of_run)
  );

endmodule
`default_nettype wire
